// File: rtl/core/afc_pkg.sv
// Shared types and constants of the box-versus-view-volume classifier.
package afc_pkg;

    localparam int NUM_PLANES   = 4;
    localparam int NUM_CORNERS  = 8;
    localparam int CFG_BITS     = 64;
    localparam int EYE_BITS     = 48;
    localparam int FAR_BITS     = 16;
    localparam int CFG_IDX_BITS = 3;
    // Two stages in each plane cell plus two in the distance unit.
    localparam int PIPE_DEPTH   = 2 * NUM_PLANES + 2;
    localparam int CNT_BITS     = $clog2(PIPE_DEPTH + 1);

    typedef logic [1:0] t_verdict;

    localparam t_verdict VERDICT_OUTSIDE  = 2'd0;
    localparam t_verdict VERDICT_STRADDLE = 2'd1;
    localparam t_verdict VERDICT_INSIDE   = 2'd2;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_index;

    localparam t_cfg_index CFG_PLANE_0 = 3'd0;
    localparam t_cfg_index CFG_PLANE_1 = 3'd1;
    localparam t_cfg_index CFG_PLANE_2 = 3'd2;
    localparam t_cfg_index CFG_PLANE_3 = 3'd3;
    localparam t_cfg_index CFG_EYE     = 3'd4;
    localparam t_cfg_index CFG_FAR     = 3'd5;

    // Plane results gathered as an item walks down the row of cells.
    typedef struct packed {
        logic       outside;
        logic [2:0] behind_cnt;
    } t_flags;

endpackage

// File: rtl/core/afc_box_if.sv
// Input channel carrying one box as its min and max corners.
interface afc_box_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] min_z;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] max_y;
    logic signed [COORD_BITS-1:0] max_z;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

// File: rtl/core/afc_verdict_if.sv
// Output channel carrying one classification verdict.
interface afc_verdict_if;
    logic              valid;
    logic              ready;
    afc_pkg::t_verdict verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

// File: rtl/core/aabb_frustum_classify.sv
// Top level of the box classifier: configuration registers and the row of cells.
// Classifies one axis-aligned box per clock, unless a held verdict has filled every stage,
// against four side planes, an eye point and a far distance. Each box passes four plane
// cells of two stages each (corner products, then eight corner sums and sign tests) and a
// two-stage distance unit (squared axis distances, then eight corner distance compares).
// Each stage holds its item while the next one is full, so a waiting verdict does not stop
// new boxes until all ten stages are occupied. The user must write configuration through
// the plain write port only while no box is in flight; the block does not enforce this.
module aabb_frustum_classify #(
    parameter int COORD_BITS           = 16,
    parameter int NORMAL_FRACTION_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    afc_box_if.sink              i_box,
    afc_verdict_if.source        o_res,
    input  logic                 i_cfg_we,
    input  afc_pkg::t_cfg_index  i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    localparam int CB = COORD_BITS;
    localparam int NP = afc_pkg::NUM_PLANES;

    logic [63:0]                r_plane [NP];
    logic [47:0]                r_eye;
    logic [15:0]                r_far;

    logic                       c_valid [NP+1];
    logic                       c_ready [NP+1];
    logic [6*CB-1:0]            c_box   [NP+1];
    afc_pkg::t_flags            c_flags [NP+1];

    logic [afc_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    logic                       in_take, out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NP; k++) begin
                r_plane[k] <= '0;
            end
            r_eye <= '0;
            r_far <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                afc_pkg::CFG_PLANE_0: r_plane[0] <= i_cfg_data;
                afc_pkg::CFG_PLANE_1: r_plane[1] <= i_cfg_data;
                afc_pkg::CFG_PLANE_2: r_plane[2] <= i_cfg_data;
                afc_pkg::CFG_PLANE_3: r_plane[3] <= i_cfg_data;
                afc_pkg::CFG_EYE:     r_eye      <= i_cfg_data[47:0];
                afc_pkg::CFG_FAR:     r_far      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign c_valid[0]  = i_box.valid;
    assign i_box.ready = c_ready[0];
    assign c_box[0]    = {i_box.max_z, i_box.max_y, i_box.max_x,
                          i_box.min_z, i_box.min_y, i_box.min_x};
    assign c_flags[0]  = '0;

    for (genvar k = 0; k < NP; k++) begin : g_cell
        afc_plane_cell #(
            .COORD_BITS           (COORD_BITS),
            .NORMAL_FRACTION_BITS (NORMAL_FRACTION_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_plane (r_plane[k]),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_box   (c_box[k]),
            .i_flags (c_flags[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_box   (c_box[k+1]),
            .o_flags (c_flags[k+1])
        );
    end

    afc_dist_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_eye     (r_eye),
        .i_far     (r_far),
        .i_valid   (c_valid[NP]),
        .o_ready   (c_ready[NP]),
        .i_box     (c_box[NP]),
        .i_flags   (c_flags[NP]),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_verdict (o_res.verdict)
    );

    // Items in flight, kept for the checks below.
    assign in_take  = i_box.valid && i_box.ready;
    assign out_take = o_res.valid && o_res.ready;

    always_comb begin
        n_cnt = r_cnt;
        if (in_take && !out_take) begin
            n_cnt = r_cnt + afc_pkg::CNT_BITS'(1);
        end else if (!in_take && out_take) begin
            n_cnt = r_cnt - afc_pkg::CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= afc_pkg::CNT_BITS'(afc_pkg::PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> r_cnt != '0)
        else $error("verdict shown with no item in flight");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_box.ready |-> (o_res.valid && !o_res.ready &&
                          r_cnt == afc_pkg::CNT_BITS'(afc_pkg::PIPE_DEPTH)))
        else $error("input stalled while the pipeline has room");

    a_zero_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_far == '0) |-> o_res.verdict != afc_pkg::VERDICT_INSIDE)
        else $error("inside verdict with zero far distance");

endmodule

// File: rtl/core/afc_plane_cell.sv
// One plane cell: tests all eight box corners against one side plane.
module afc_plane_cell #(
    parameter int COORD_BITS           = 16,
    parameter int NORMAL_FRACTION_BITS = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [63:0]             i_plane,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [6*COORD_BITS-1:0] i_box,
    input  afc_pkg::t_flags         i_flags,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [6*COORD_BITS-1:0] o_box,
    output afc_pkg::t_flags         o_flags
);
    localparam int CB = COORD_BITS;
    localparam int NB = NORMAL_FRACTION_BITS + 2;
    localparam int PW = NB + CB;
    localparam int SW = (NB + CB + 2 > 64) ? 64 : NB + CB + 2;
    localparam int BW = 6 * CB;

    logic [127:0]          plane_ext;
    logic signed [NB-1:0]  nrm [3];
    logic signed [CB-1:0]  doff;
    logic signed [SW-1:0]  d_term;

    logic                  r_va, r_vb;
    logic                  en_a, en_b;
    logic [BW-1:0]         r_box_a, r_box_b;
    afc_pkg::t_flags       r_flags_a, r_flags_b, n_flags;
    logic signed [PW-1:0]  r_prod_lo [3];
    logic signed [PW-1:0]  r_prod_hi [3];
    logic signed [PW-1:0]  n_prod_lo [3];
    logic signed [PW-1:0]  n_prod_hi [3];

    logic signed [CB-1:0]  lo_c, hi_c;
    logic signed [SW-1:0]  t0, t1, t2, s_sum;
    logic                  all_front, all_back;

    // Fields that start past bit 63 read as zero.
    assign plane_ext = {64'b0, i_plane};
    assign doff      = plane_ext[3*CB +: CB];
    assign d_term    = {{(SW-CB-NORMAL_FRACTION_BITS){doff[CB-1]}}, doff,
                        {NORMAL_FRACTION_BITS{1'b0}}};

    for (genvar a = 0; a < 3; a++) begin : g_nrm
        assign nrm[a] = plane_ext[a*NB +: NB];
    end

    assign en_b    = !r_vb || i_ready;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vb;
    assign o_box   = r_box_b;
    assign o_flags = r_flags_b;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lo_c         = i_box[a*CB +: CB];
            hi_c         = i_box[(a+3)*CB +: CB];
            n_prod_lo[a] = PW'(nrm[a]) * PW'(lo_c);
            n_prod_hi[a] = PW'(nrm[a]) * PW'(hi_c);
        end
    end

    always_comb begin
        all_front = 1'b1;
        all_back  = 1'b1;
        for (int i = 0; i < afc_pkg::NUM_CORNERS; i++) begin
            t0        = SW'((((i >> 0) & 1) != 0) ? r_prod_hi[0] : r_prod_lo[0]);
            t1        = SW'((((i >> 1) & 1) != 0) ? r_prod_hi[1] : r_prod_lo[1]);
            t2        = SW'((((i >> 2) & 1) != 0) ? r_prod_hi[2] : r_prod_lo[2]);
            s_sum     = t0 + t1 + t2 + d_term;
            all_front = all_front && (s_sum != '0) && !s_sum[SW-1];
            all_back  = all_back && s_sum[SW-1];
        end
        n_flags.outside    = r_flags_a.outside | all_front;
        n_flags.behind_cnt = r_flags_a.behind_cnt + (all_back ? 3'd1 : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_box_a   <= i_box;
            r_flags_a <= i_flags;
            r_prod_lo <= n_prod_lo;
            r_prod_hi <= n_prod_hi;
        end
        if (en_b && r_va) begin
            r_box_b   <= r_box_a;
            r_flags_b <= n_flags;
        end
    end

endmodule

// File: rtl/core/afc_dist_unit.sv
// Last cell: eye containment, far-distance test and the final verdict.
module afc_dist_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [47:0]             i_eye,
    input  logic [15:0]             i_far,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [6*COORD_BITS-1:0] i_box,
    input  afc_pkg::t_flags         i_flags,
    output logic                    o_valid,
    input  logic                    i_ready,
    output afc_pkg::t_verdict       o_verdict
);
    localparam int CB   = COORD_BITS;
    localparam int SQW  = 2 * CB + 2;
    localparam int SUMW = 2 * CB + 4;
    localparam int DW   = (SUMW > 64) ? 64 : SUMW;
    localparam int CW   = (DW > 32) ? DW : 32;

    logic [127:0]          eye_ext;
    logic signed [CB-1:0]  eye [3];

    logic                  r_va, r_vb;
    logic                  en_a, en_b;
    afc_pkg::t_flags       r_flags;
    logic                  r_eye_in;
    logic [31:0]           r_far_sq;
    logic [SQW-1:0]        r_sq_lo [3];
    logic [SQW-1:0]        r_sq_hi [3];
    logic [SQW-1:0]        n_sq_lo [3];
    logic [SQW-1:0]        n_sq_hi [3];
    logic                  n_eye_in;
    afc_pkg::t_verdict     r_verdict, n_verdict;

    logic signed [CB-1:0]  lo_c, hi_c;
    logic signed [CB:0]    e_w, lo_w, hi_w, dl, dh;
    logic [CB:0]           abs_lo, abs_hi;
    logic [SUMW-1:0]       d2_full;
    logic [DW-1:0]         d2;
    logic [CW-1:0]         d2_c, far_c;
    logic                  all_near, all_far;

    assign eye_ext = {80'b0, i_eye};
    for (genvar a = 0; a < 3; a++) begin : g_eye
        assign eye[a] = eye_ext[a*CB +: CB];
    end

    assign en_b      = !r_vb || i_ready;
    assign en_a      = !r_va || en_b;
    assign o_ready   = en_a;
    assign o_valid   = r_vb;
    assign o_verdict = r_verdict;

    always_comb begin
        n_eye_in = 1'b1;
        for (int a = 0; a < 3; a++) begin
            lo_c       = i_box[a*CB +: CB];
            hi_c       = i_box[(a+3)*CB +: CB];
            n_eye_in   = n_eye_in && (eye[a] > lo_c) && (eye[a] < hi_c);
            e_w        = {eye[a][CB-1], eye[a]};
            lo_w       = {lo_c[CB-1], lo_c};
            hi_w       = {hi_c[CB-1], hi_c};
            dl         = e_w - lo_w;
            dh         = e_w - hi_w;
            abs_lo     = dl[CB] ? (CB+1)'(-dl) : (CB+1)'(dl);
            abs_hi     = dh[CB] ? (CB+1)'(-dh) : (CB+1)'(dh);
            n_sq_lo[a] = SQW'(abs_lo) * SQW'(abs_lo);
            n_sq_hi[a] = SQW'(abs_hi) * SQW'(abs_hi);
        end
    end

    always_comb begin
        all_near = 1'b1;
        all_far  = 1'b1;
        far_c    = CW'(r_far_sq);
        for (int i = 0; i < afc_pkg::NUM_CORNERS; i++) begin
            d2_full = SUMW'((((i >> 0) & 1) != 0) ? r_sq_hi[0] : r_sq_lo[0])
                    + SUMW'((((i >> 1) & 1) != 0) ? r_sq_hi[1] : r_sq_lo[1])
                    + SUMW'((((i >> 2) & 1) != 0) ? r_sq_hi[2] : r_sq_lo[2]);
            d2       = d2_full[DW-1:0];
            d2_c     = CW'(d2);
            all_near = all_near && (d2_c < far_c);
            all_far  = all_far && (d2_c > far_c);
        end
        if (r_flags.outside) begin
            n_verdict = afc_pkg::VERDICT_OUTSIDE;
        end else if (r_eye_in) begin
            n_verdict = afc_pkg::VERDICT_STRADDLE;
        end else if (all_far) begin
            n_verdict = afc_pkg::VERDICT_OUTSIDE;
        end else if (all_near && r_flags.behind_cnt == 3'(afc_pkg::NUM_PLANES)) begin
            n_verdict = afc_pkg::VERDICT_INSIDE;
        end else begin
            n_verdict = afc_pkg::VERDICT_STRADDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_flags  <= i_flags;
            r_eye_in <= n_eye_in;
            r_far_sq <= 32'(i_far) * 32'(i_far);
            r_sq_lo  <= n_sq_lo;
            r_sq_hi  <= n_sq_hi;
        end
        if (en_b && r_va) begin
            r_verdict <= n_verdict;
        end
    end

endmodule

// File: test/aabb_frustum_classify_tb.sv
// Self-checking testbench for the box classifier: directed and random traffic against a built-in predictor.
module aabb_frustum_classify_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint NORMAL_SCALE = 64'sd1 << 14;
    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     RANDOM_PHASES = 8;
    localparam int     BOXES_PER_PHASE = 215;

    // Indexes beyond the last register; writes to them must change nothing.
    localparam afc_pkg::t_cfg_index CFG_UNMAPPED_LO = 3'd6;
    localparam afc_pkg::t_cfg_index CFG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic signed [15:0] max_z;
        logic signed [15:0] max_y;
        logic signed [15:0] max_x;
        logic signed [15:0] min_z;
        logic signed [15:0] min_y;
        logic signed [15:0] min_x;
    } t_box;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    afc_pkg::t_cfg_index i_cfg_index;
    logic [63:0]         i_cfg_data;

    afc_box_if #(.COORD_BITS(16)) box_ch ();
    afc_verdict_if                res_ch ();

    aabb_frustum_classify uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (box_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the view registers as the block should hold them.
    logic [63:0] plane_reg [afc_pkg::NUM_PLANES];
    logic [47:0] eye_reg;
    logic [15:0] far_reg;

    t_box              pending_boxes[$];
    afc_pkg::t_verdict expected_verdicts[$];

    int boxes_accepted = 0;
    int verdicts_checked = 0;
    int mismatches = 0;
    int view_settings = 0;
    int long_holds = 0;
    int idle_cycles = 0;
    int verdict_tally [4] = '{default: 0};

    function automatic afc_pkg::t_verdict classify_box(t_box b);
        longint lo [3];
        longint hi [3];
        longint eye_c [3];
        longint pt [3];
        longint acc, dd, d2, far_sq;
        int front, back, behind_all, near_cnt, far_cnt;
        lo[0] = b.min_x;
        lo[1] = b.min_y;
        lo[2] = b.min_z;
        hi[0] = b.max_x;
        hi[1] = b.max_y;
        hi[2] = b.max_z;
        for (int a = 0; a < 3; a++)
            eye_c[a] = longint'($signed(eye_reg[a*16 +: 16]));

        behind_all = 0;
        for (int j = 0; j < afc_pkg::NUM_PLANES; j++) begin
            front = 0;
            back = 0;
            for (int i = 0; i < afc_pkg::NUM_CORNERS; i++) begin
                acc = longint'($signed(plane_reg[j][63:48])) * NORMAL_SCALE;
                for (int a = 0; a < 3; a++) begin
                    pt[a] = i[a] ? hi[a] : lo[a];
                    acc += longint'($signed(plane_reg[j][a*16 +: 16])) * pt[a];
                end
                if (acc > 0)
                    front++;
                else if (acc < 0)
                    back++;
            end
            if (front == afc_pkg::NUM_CORNERS)
                return afc_pkg::VERDICT_OUTSIDE;
            if (back == afc_pkg::NUM_CORNERS)
                behind_all++;
        end

        if (eye_c[0] > lo[0] && eye_c[0] < hi[0] && eye_c[1] > lo[1] && eye_c[1] < hi[1] &&
            eye_c[2] > lo[2] && eye_c[2] < hi[2])
            return afc_pkg::VERDICT_STRADDLE;

        far_sq = longint'(far_reg) * longint'(far_reg);
        near_cnt = 0;
        far_cnt = 0;
        for (int i = 0; i < afc_pkg::NUM_CORNERS; i++) begin
            d2 = 0;
            for (int a = 0; a < 3; a++) begin
                dd = eye_c[a] - (i[a] ? hi[a] : lo[a]);
                d2 += dd * dd;
            end
            if (d2 < far_sq)
                near_cnt++;
            else if (d2 > far_sq)
                far_cnt++;
        end

        if (far_cnt == afc_pkg::NUM_CORNERS)
            return afc_pkg::VERDICT_OUTSIDE;
        if (near_cnt == afc_pkg::NUM_CORNERS && behind_all == afc_pkg::NUM_PLANES)
            return afc_pkg::VERDICT_INSIDE;
        return afc_pkg::VERDICT_STRADDLE;
    endfunction

    function automatic logic [15:0] clamp16(int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic int srand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [63:0] pack_plane(logic [15:0] nx, logic [15:0] ny,
                                               logic [15:0] nz, logic [15:0] d);
        return {d, nz, ny, nx};
    endfunction

    function automatic logic [47:0] pack_eye(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    // Most boxes sit in the viewing direction near the eye so that every verdict shows up.
    function automatic t_box make_box();
        t_box b;
        int kind, ex, ey, ez, f, cx, cy, cz, sx, sy, sz, flip;
        logic [15:0] t;
        kind = $urandom_range(0, 99);
        if (kind >= 85) begin
            b = {$urandom(), $urandom(), $urandom()};
            if (kind >= 93) begin
                b.min_x = pick_extreme();
                b.min_y = pick_extreme();
                b.min_z = pick_extreme();
                b.max_x = pick_extreme();
                b.max_y = pick_extreme();
                b.max_z = pick_extreme();
            end
            return b;
        end
        ex = $signed(eye_reg[15:0]);
        ey = $signed(eye_reg[31:16]);
        ez = $signed(eye_reg[47:32]);
        f = (far_reg == 0) ? 2000 : int'(far_reg);
        cx = ex + srand(f / 2);
        cy = ey + srand(f / 2);
        cz = ($urandom_range(0, 9) == 0) ? ez + srand(8) : ez + int'($urandom_range(0, f));
        sx = $urandom_range(0, f / 4 + 1);
        sy = $urandom_range(0, f / 4 + 1);
        sz = $urandom_range(0, f / 4 + 1);
        b.min_x = clamp16(cx - sx);
        b.min_y = clamp16(cy - sy);
        b.min_z = clamp16(cz - sz);
        b.max_x = clamp16(cx + sx);
        b.max_y = clamp16(cy + sy);
        b.max_z = clamp16(cz + sz);
        if (kind >= 75) begin
            flip = $urandom_range(1, 7);
            if (flip[0]) begin
                t = b.min_x;
                b.min_x = b.max_x;
                b.max_x = t;
            end
            if (flip[1]) begin
                t = b.min_y;
                b.min_y = b.max_y;
                b.max_y = t;
            end
            if (flip[2]) begin
                t = b.min_z;
                b.min_z = b.max_z;
                b.max_z = t;
            end
        end
        return b;
    endfunction

    task automatic push_box(int x0, int y0, int z0, int x1, int y1, int z1);
        t_box b;
        b.min_x = clamp16(x0);
        b.min_y = clamp16(y0);
        b.min_z = clamp16(z0);
        b.max_x = clamp16(x1);
        b.max_y = clamp16(y1);
        b.max_z = clamp16(z1);
        pending_boxes.push_back(b);
    endtask

    // Called at a rising edge; returns at the edge where the write took place.
    task automatic write_reg(afc_pkg::t_cfg_index idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            afc_pkg::CFG_PLANE_0, afc_pkg::CFG_PLANE_1,
            afc_pkg::CFG_PLANE_2, afc_pkg::CFG_PLANE_3: plane_reg[idx[1:0]] = data;
            afc_pkg::CFG_EYE: eye_reg = data[47:0];
            afc_pkg::CFG_FAR: far_reg = data[15:0];
            default: ;
        endcase
    endtask

    task automatic load_view(logic [63:0] p0, logic [63:0] p1, logic [63:0] p2,
                             logic [63:0] p3, logic [47:0] eye, logic [15:0] far_dist);
        write_reg(afc_pkg::CFG_PLANE_0, p0);
        write_reg(afc_pkg::CFG_PLANE_1, p1);
        write_reg(CFG_UNMAPPED_LO, {$urandom(), $urandom()});
        write_reg(afc_pkg::CFG_PLANE_2, p2);
        write_reg(afc_pkg::CFG_PLANE_3, p3);
        write_reg(afc_pkg::CFG_EYE, {$urandom(), $urandom()} & 64'h0 | {16'hA5A5, eye});
        write_reg(CFG_UNMAPPED_HI, {$urandom(), $urandom()});
        write_reg(afc_pkg::CFG_FAR, {$urandom(), 16'h0, far_dist});
        i_cfg_we <= 1'b0;
        view_settings++;
    endtask

    // Four side planes through a random eye, opening toward positive z.
    task automatic load_frustum(int far_lo, int far_hi);
        logic [63:0] pl [afc_pkg::NUM_PLANES];
        int ex, ey, ez, nl, nx, ny, nz, dot;
        ex = srand(8000);
        ey = srand(8000);
        ez = srand(8000);
        for (int k = 0; k < afc_pkg::NUM_PLANES; k++) begin
            nl = int'($urandom_range(4000, 16000)) * ((k % 2 == 0) ? 1 : -1);
            nz = -int'($urandom_range(4000, 16000));
            nx = (k < 2) ? nl : 0;
            ny = (k < 2) ? 0 : nl;
            dot = nx * ex + ny * ey + nz * ez;
            pl[k] = pack_plane(16'(nx), 16'(ny), 16'(nz), 16'(-(dot / 16384)));
        end
        load_view(pl[0], pl[1], pl[2], pl[3], pack_eye(16'(ex), 16'(ey), 16'(ez)),
                  16'($urandom_range(far_lo, far_hi)));
    endtask

    // Returns at a rising edge once every box has been classified and the pipe is empty.
    task automatic drain();
        while (pending_boxes.size() != 0 || expected_verdicts.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
        repeat (afc_pkg::PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        logic nxt_valid;
        t_box taken;
        if (!i_rst_n) begin
            box_ch.valid <= 1'b0;
        end else begin
            if (box_ch.valid && box_ch.ready && pending_boxes.size() != 0) begin
                taken = pending_boxes.pop_front();
                expected_verdicts.push_back(classify_box(taken));
                boxes_accepted++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (box_ch.valid && !box_ch.ready) begin
                nxt_valid = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                nxt_valid = 1'b0;
            end else if (pending_boxes.size() == 0) begin
                nxt_valid = 1'b0;
            end else begin
                nxt_valid = 1'b1;
                box_ch.min_x <= pending_boxes[0].min_x;
                box_ch.min_y <= pending_boxes[0].min_y;
                box_ch.min_z <= pending_boxes[0].min_z;
                box_ch.max_x <= pending_boxes[0].max_x;
                box_ch.max_y <= pending_boxes[0].max_y;
                box_ch.max_z <= pending_boxes[0].max_z;
            end
            box_ch.valid <= nxt_valid;
        end
    end

    // Receiver: stretches of varying stall rate, plus long hold-offs that fill the pipe.
    int stall_pct = 0;
    int pattern_left = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        afc_pkg::t_verdict want;
        logic rdy;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                verdicts_checked++;
                if (!$isunknown(res_ch.verdict))
                    verdict_tally[res_ch.verdict]++;
                if (expected_verdicts.size() == 0) begin
                    note_mismatch($sformatf("verdict %0d with no box outstanding",
                                            res_ch.verdict));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (res_ch.verdict !== want)
                        note_mismatch($sformatf("verdict %0d: expected %0d, got %0d",
                                                verdicts_checked, want, res_ch.verdict));
                end
                if (verdicts_checked == 400 || verdicts_checked == 1300) begin
                    hold_left = 60;
                    long_holds++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(30, 200);
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 20;
                        3: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                pattern_left--;
                rdy = ($urandom_range(0, 99) >= stall_pct);
            end
            res_ch.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if ((box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = afc_pkg::CFG_PLANE_0;
        i_cfg_data = 64'h0;
        box_ch.valid = 1'b0;
        box_ch.min_x = 16'h0;
        box_ch.min_y = 16'h0;
        box_ch.min_z = 16'h0;
        box_ch.max_x = 16'h0;
        box_ch.max_y = 16'h0;
        box_ch.max_z = 16'h0;
        res_ch.ready = 1'b0;
        for (int k = 0; k < afc_pkg::NUM_PLANES; k++)
            plane_reg[k] = 64'h0;
        eye_reg = 48'h0;
        far_reg = 16'h0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Symmetric view along +z from the origin, far distance 1000.
        load_view(pack_plane(11585, 0, -11585, 0), pack_plane(-11585, 0, -11585, 0),
                  pack_plane(0, 11585, -11585, 0), pack_plane(0, -11585, -11585, 0),
                  pack_eye(0, 0, 0), 16'd1000);
        @(negedge i_clk);
        push_box(-20, -20, 100, 20, 20, 200);
        push_box(500, -10, 100, 600, 10, 200);
        push_box(-10, 500, 100, 10, 600, 200);
        push_box(-10, -10, -300, 10, 10, -200);
        push_box(-10, -10, -10, 10, 10, 10);
        push_box(-10, -10, 2000, 10, 10, 2100);
        push_box(50, -10, 100, 300, 10, 200);
        push_box(-10, -10, 900, 10, 10, 1100);
        // A single corner lying exactly on a side plane.
        push_box(100, 0, 100, 100, 0, 100);
        // Inverted boxes, one of them around the eye.
        push_box(20, 20, 200, -20, -20, 100);
        push_box(10, 10, 10, -10, -10, -10);
        // Corners exactly at the far distance.
        push_box(0, 0, 1000, 0, 0, 1000);
        push_box(0, 600, 800, 0, 600, 800);
        // Eye on a face of the box.
        push_box(0, -5, -5, 10, 5, 5);
        push_box(-32768, -32768, -32768, 32767, 32767, 32767);
        push_box(-32768, -32768, -32768, -32768, -32768, -32768);
        push_box(32767, 32767, 32767, 32767, 32767, 32767);
        push_box(32767, -32768, 32767, -32768, 32767, -32768);
        push_box(-1, 0, -1, 0, -1, 0);
        push_box(21845, -21846, 21845, -21846, 21845, -21846);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                1: load_view({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                             pack_eye(16'h7FFF, 16'h7FFF, 16'h7FFF), 16'hFFFF);
                3: load_frustum(0, 0);
                4: load_view({$urandom(), $urandom()}, {$urandom(), $urandom()},
                             {$urandom(), $urandom()}, {$urandom(), $urandom()},
                             48'({$urandom(), $urandom()}), 16'($urandom()));
                5: load_view(64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF,
                             64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF,
                             pack_eye(16'h8000, 16'h8000, 16'h8000), 16'hFFFF);
                7: load_frustum(1, 300);
                default: load_frustum(200, 20000);
            endcase
            @(negedge i_clk);
            for (int n = 0; n < BOXES_PER_PHASE; n++)
                pending_boxes.push_back(make_box());
            drain();
        end

        $display("classified %0d boxes under %0d view settings, %0d verdicts checked",
                 boxes_accepted, view_settings, verdicts_checked);
        $display("outside %0d, straddling %0d, inside %0d; %0d long receiver hold-offs",
                 verdict_tally[afc_pkg::VERDICT_OUTSIDE],
                 verdict_tally[afc_pkg::VERDICT_STRADDLE],
                 verdict_tally[afc_pkg::VERDICT_INSIDE], long_holds);
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d verdicts missing", mismatches,
                     expected_verdicts.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
